// ----- hdl/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared widths, operation codes, status codes and cell command codes.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ELEM_BITS_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SET    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_GET    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OOB   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef logic [2:0] cmd_kind_t;

    localparam cmd_kind_t CMD_NONE    = 3'd0;
    localparam cmd_kind_t CMD_LOAD    = 3'd1;
    localparam cmd_kind_t CMD_INSERT  = 3'd2;
    localparam cmd_kind_t CMD_REMOVE  = 3'd3;
    localparam cmd_kind_t CMD_CAPTURE = 3'd4;

endpackage

// ----- hdl/ile_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine cell
// Holds one list element and one stage of the read-out chain. The cell
// compares its own index with the broadcast index to choose its next value.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int DEPTH     = ile_pkg::DEPTH_DEF,
    parameter int ELEM_BITS = ile_pkg::ELEM_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  logic                       clk,
    input  ile_pkg::cmd_kind_t         kind,
    input  logic [$clog2(DEPTH)-1:0]   idx,
    input  logic [ELEM_BITS-1:0]       data,
    input  logic [ELEM_BITS-1:0]       left_entry,
    input  logic [ELEM_BITS-1:0]       right_entry,
    input  logic [ELEM_BITS-1:0]       right_chain,
    output logic [ELEM_BITS-1:0]       entry,
    output logic [ELEM_BITS-1:0]       chain
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [ELEM_BITS-1:0] entry_reg;
    logic [ELEM_BITS-1:0] entry_next;
    logic [ELEM_BITS-1:0] chain_reg;
    logic [ELEM_BITS-1:0] chain_next;
    logic                 at_idx;
    logic                 above_idx;

    assign at_idx    = (idx == IDX_W'(INDEX));
    assign above_idx = (IDX_W'(INDEX) > idx);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (kind)
            ile_pkg::CMD_LOAD:
            begin
                if (at_idx)
                begin
                    entry_next = data;
                end
            end
            ile_pkg::CMD_INSERT:
            begin
                if (at_idx)
                begin
                    entry_next = data;
                end
                else if (above_idx)
                begin
                    entry_next = left_entry;
                end
            end
            ile_pkg::CMD_REMOVE:
            begin
                if (at_idx || above_idx)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_comb
    begin
        if (kind == ile_pkg::CMD_CAPTURE)
        begin
            chain_next = at_idx ? entry_reg : '0;
        end
        else
        begin
            chain_next = right_chain;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        chain_reg <= chain_next;
    end

    assign entry = entry_reg;
    assign chain = chain_reg;

endmodule

// ----- hdl/indexed_list_engine_core.sv -----
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of up to DEPTH elements with push, pop, set, get, insert and
// remove, built as a row of element cells.
// ----------------------------------------------------------------------------
// Every operation that is not refused updates the row of cells in the cycle of
// its input transfer, since each cell decides its own shift from its index
// against the operation's index. Pop and get read the element through a
// registered chain that moves one cell towards index zero per cycle; from cell
// zero it goes into the pending register and then the output register. All
// other operations, refused ones included, go straight into the pending
// register and on the same way. One item is processed at a time: a new item
// is not taken in while the previous one is in the read chain or the pending
// register; a finished result may wait in the output register while the next
// item is taken in. After reset the list is empty and no clearing pass is needed.
module indexed_list_engine_core #(
    parameter int DEPTH     = ile_pkg::DEPTH_DEF,
    parameter int ELEM_BITS = ile_pkg::ELEM_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ile_pkg::OPCODE_W-1:0]   opcode,
    input  logic [ile_pkg::POS_W-1:0]      position,
    input  logic [ile_pkg::DATA_W-1:0]     data_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ile_pkg::STATUS_W-1:0]   status,
    output logic [ile_pkg::DATA_W-1:0]     data_out,
    output logic [ile_pkg::COUNT_W-1:0]    count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = ile_pkg::POS_W;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DW    = ile_pkg::DATA_W;
    localparam int CW    = ile_pkg::COUNT_W;

    logic [ELEM_BITS-1:0] entry_w [DEPTH];
    logic [ELEM_BITS-1:0] chain_w [DEPTH];
    logic [ELEM_BITS-1:0] left_w  [DEPTH];
    logic [ELEM_BITS-1:0] right_w [DEPTH];
    logic [ELEM_BITS-1:0] rchain_w[DEPTH];

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          rd_busy_reg;
    logic [IDX_W-1:0]              rd_wait_reg;
    logic                          pend_valid_reg;
    logic [ile_pkg::STATUS_W-1:0]  pend_status_reg;
    logic [CNT_W-1:0]              pend_count_reg;
    logic [ELEM_BITS-1:0]          pend_data_reg;
    logic                          out_valid_reg;
    logic [ile_pkg::STATUS_W-1:0]  out_status_reg;
    logic [CNT_W-1:0]              out_count_reg;
    logic [ELEM_BITS-1:0]          out_data_reg;

    logic                          accept;
    logic                          out_free;
    logic [CMP_W-1:0]              pos_ext;
    logic [CMP_W-1:0]              cnt_ext;
    logic                          full;
    logic                          empty;
    logic [ile_pkg::STATUS_W-1:0]  st;
    logic                          is_read;
    ile_pkg::cmd_kind_t            op_kind;
    ile_pkg::cmd_kind_t            kind;
    logic [IDX_W-1:0]              idx;
    logic [ELEM_BITS-1:0]          elem;

    assign in_stall = rd_busy_reg | pend_valid_reg;
    assign accept   = in_valid & ~in_stall;
    assign out_free = ~out_valid_reg | ~out_stall;

    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign elem    = ELEM_BITS'(data_in);

    always_comb
    begin
        st       = ile_pkg::ST_OK;
        op_kind  = ile_pkg::CMD_NONE;
        is_read  = 1'b0;
        cnt_next = cnt_reg;
        idx      = pos_ext[IDX_W-1:0];
        unique case (opcode)
            ile_pkg::OP_PUSH:
            begin
                idx = cnt_ext[IDX_W-1:0];
                if (full)
                begin
                    st = ile_pkg::ST_FULL;
                end
                else
                begin
                    op_kind  = ile_pkg::CMD_LOAD;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ile_pkg::OP_POP:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                idx      = cnt_next[IDX_W-1:0];
                if (empty)
                begin
                    st       = ile_pkg::ST_EMPTY;
                    cnt_next = cnt_reg;
                end
                else
                begin
                    op_kind = ile_pkg::CMD_CAPTURE;
                    is_read = 1'b1;
                end
            end
            ile_pkg::OP_SET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    st = ile_pkg::ST_OOB;
                end
                else
                begin
                    op_kind = ile_pkg::CMD_LOAD;
                end
            end
            ile_pkg::OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                begin
                    st = ile_pkg::ST_OOB;
                end
                else if (full)
                begin
                    st = ile_pkg::ST_FULL;
                end
                else
                begin
                    op_kind  = ile_pkg::CMD_INSERT;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ile_pkg::OP_GET:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    st = ile_pkg::ST_OOB;
                end
                else
                begin
                    op_kind = ile_pkg::CMD_CAPTURE;
                    is_read = 1'b1;
                end
            end
            ile_pkg::OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    st = ile_pkg::ST_OOB;
                end
                else
                begin
                    op_kind  = ile_pkg::CMD_REMOVE;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                st = ile_pkg::ST_OK;
            end
        endcase
    end

    assign kind = accept ? op_kind : ile_pkg::CMD_NONE;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_w[g] = '0;
            end
            else
            begin : g_mid_l
                assign left_w[g] = entry_w[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign right_w[g]  = '0;
                assign rchain_w[g] = '0;
            end
            else
            begin : g_mid_r
                assign right_w[g]  = entry_w[g+1];
                assign rchain_w[g] = chain_w[g+1];
            end

            ile_cell #(
                .DEPTH     (DEPTH),
                .ELEM_BITS (ELEM_BITS),
                .INDEX     (g)
            ) u_cell (
                .clk         (clk),
                .kind        (kind),
                .idx         (idx),
                .data        (elem),
                .left_entry  (left_w[g]),
                .right_entry (right_w[g]),
                .right_chain (rchain_w[g]),
                .entry       (entry_w[g]),
                .chain       (chain_w[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rd_busy_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
                if (is_read)
                begin
                    rd_busy_reg <= 1'b1;
                end
                else
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            else if (rd_busy_reg && (rd_wait_reg == '0))
            begin
                rd_busy_reg    <= 1'b0;
                pend_valid_reg <= 1'b1;
            end
            else if (pend_valid_reg && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (pend_valid_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_wait_reg     <= idx;
            pend_status_reg <= st;
            pend_count_reg  <= cnt_next;
            pend_data_reg   <= '0;
        end
        else if (rd_busy_reg)
        begin
            if (rd_wait_reg == '0)
            begin
                pend_data_reg <= chain_w[0];
            end
            else
            begin
                rd_wait_reg <= rd_wait_reg - IDX_W'(1);
            end
        end

        if (pend_valid_reg && out_free)
        begin
            out_status_reg <= pend_status_reg;
            out_count_reg  <= pend_count_reg;
            out_data_reg   <= pend_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign data_out  = DW'(out_data_reg);
    assign count     = CW'(out_count_reg);

endmodule
